// ===== design/rcp_pkg.sv =====
package rcp_pkg;

	localparam logic [1:0] STATUS_COLOR     = 2'd0;
	localparam logic [1:0] STATUS_MALFORMED = 2'd1;
	localparam logic [1:0] STATUS_OTHER     = 2'd2;

	localparam logic       CMD_BYTE = 1'b0;
	localparam logic       CMD_TICK = 1'b1;

	// Position of a character within the "RGB:" prefix, or none
	localparam logic [2:0] PFX_R     = 3'd0;
	localparam logic [2:0] PFX_G     = 3'd1;
	localparam logic [2:0] PFX_B     = 3'd2;
	localparam logic [2:0] PFX_COLON = 3'd3;
	localparam logic [2:0] PFX_NONE  = 3'd4;

	localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd1000;
	localparam logic [7:0]  BRIGHTNESS_FULL    = 8'd255;
	localparam logic [1:0]  LAST_COMMA         = 2'd3;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] brightness;
		logic [5:0] line_length;
	} rsp_t;

	// Request after classification by the front end
	typedef struct packed {
		logic       is_tick;
		logic       is_eol;
		logic       is_zero;
		logic       is_comma;
		logic       is_blank;
		logic       is_sign;
		logic       is_minus;
		logic       is_digit;
		logic [3:0] digit;
		logic [2:0] pfx_code;
	} item_t;

endpackage

// ===== design/rcp_front.sv =====
module rcp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rcp_pkg::req_t  in_data,
	output logic           item_valid,
	input  logic           item_pop,
	output rcp_pkg::item_t item
);
	import rcp_pkg::*;

	item_t      cls;
	item_t      queue_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic [7:0] c;

	assign c = in_data.data_byte;

	always_comb begin
		cls          = '0;
		cls.is_tick  = (in_data.command == CMD_TICK);
		cls.is_eol   = (in_data.command == CMD_BYTE) && (c == 8'h0A || c == 8'h0D);
		cls.is_zero  = (c == 8'h00);
		cls.is_comma = (c == 8'h2C);
		cls.is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
		cls.is_sign  = (c == 8'h2B) || (c == 8'h2D);
		cls.is_minus = (c == 8'h2D);
		cls.is_digit = (c >= 8'h30) && (c <= 8'h39);
		cls.digit    = c[3:0];
		case (c)
			8'h52:   cls.pfx_code = PFX_R;
			8'h47:   cls.pfx_code = PFX_G;
			8'h42:   cls.pfx_code = PFX_B;
			8'h3A:   cls.pfx_code = PFX_COLON;
			default: cls.pfx_code = PFX_NONE;
		endcase
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign item_valid = (count_q != 2'd0);
	assign item       = queue_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (item_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, item_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/rcp_back.sv =====
module rcp_back #(
	parameter int LINE_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_pop,
	input  rcp_pkg::item_t item,
	input  logic           cfg_valid,
	input  logic [15:0]    cfg_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rcp_pkg::rsp_t  out_data
);
	import rcp_pkg::*;

	localparam int CW = $clog2(LINE_DEPTH);

	typedef enum logic [1:0] {PH_LEAD, PH_DIGITS, PH_DONE} phase_t;

	localparam logic [2:0] PFX_MATCHED  = 3'd4;
	localparam logic [2:0] PFX_MISMATCH = 3'd5;

	logic [15:0]   timeout_q;
	logic [15:0]   idle_q, idle_n;
	logic [CW-1:0] stored_q, stored_n;
	logic [2:0]    prog_q, prog_n;
	logic [1:0]    cc_q, cc_n;
	phase_t        phase_q, phase_n;
	logic [8:0]    acc_q, acc_n;
	logic          neg_q, neg_n;
	logic          err_q, err_n;
	logic          ended_q, ended_n;
	logic [7:0]    fields_q [4];

	logic          field_we;
	logic          clear;
	logic          load_out;
	logic          close_err;
	logic [12:0]   acc_mul;
	logic [8:0]    acc_sat;
	rsp_t          res;
	logic          out_valid_q;
	rsp_t          out_data_q;

	// hold only a line end while the output register is occupied
	assign item_pop  = item_valid && (!item.is_eol || !out_valid_q || out_ready);
	assign close_err = acc_q[8] || (neg_q && (acc_q != 9'd0));
	assign acc_mul   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {9'd0, item.digit};
	assign acc_sat   = (acc_mul > 13'd256) ? 9'd256 : acc_mul[8:0];

	always_comb begin
		idle_n   = idle_q;
		stored_n = stored_q;
		prog_n   = prog_q;
		cc_n     = cc_q;
		phase_n  = phase_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		err_n    = err_q;
		ended_n  = ended_q;
		field_we = 1'b0;
		clear    = 1'b0;
		load_out = 1'b0;
		res      = '0;
		if (item_pop) begin
			if (item.is_tick) begin
				idle_n = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
				if ((stored_q != '0) && (idle_n > timeout_q)) begin
					clear = 1'b1;
				end
			end else if (item.is_eol) begin
				idle_n = '0;
				if (stored_q != '0) begin
					load_out        = 1'b1;
					clear           = 1'b1;
					res.line_length = 6'(stored_q);
					if (prog_q != PFX_MATCHED) begin
						res.status = STATUS_OTHER;
					end else if (cc_q < 2'd2) begin
						res.status = STATUS_MALFORMED;
					end else if (err_q || close_err) begin
						res.status = STATUS_MALFORMED;
					end else begin
						res.status     = STATUS_COLOR;
						res.red        = fields_q[0];
						res.green      = fields_q[1];
						res.blue       = (cc_q == 2'd2) ? acc_q[7:0] : fields_q[2];
						res.brightness = (cc_q == 2'd2) ? BRIGHTNESS_FULL : acc_q[7:0];
					end
				end
			end else begin
				idle_n = '0;
				if (stored_q < CW'(LINE_DEPTH - 1)) begin
					stored_n = stored_q + CW'(1);
					if (!ended_q) begin
						if (item.is_zero) begin
							ended_n = 1'b1;
						end else if (prog_q < PFX_MATCHED) begin
							prog_n = (item.pfx_code == prog_q) ? prog_q + 3'd1 : PFX_MISMATCH;
						end else if (prog_q == PFX_MATCHED) begin
							if (item.is_comma && (cc_q != LAST_COMMA)) begin
								field_we = 1'b1;
								err_n    = err_q || close_err;
								phase_n  = PH_LEAD;
								acc_n    = '0;
								neg_n    = 1'b0;
								cc_n     = cc_q + 2'd1;
							end else begin
								case (phase_q)
									PH_LEAD: begin
										if (item.is_blank) begin
											phase_n = PH_LEAD;
										end else if (item.is_sign) begin
											neg_n   = item.is_minus;
											phase_n = PH_DIGITS;
										end else if (item.is_digit) begin
											phase_n = PH_DIGITS;
											acc_n   = acc_sat;
										end else begin
											phase_n = PH_DONE;
										end
									end
									PH_DIGITS: begin
										if (item.is_digit) begin
											acc_n = acc_sat;
										end else begin
											phase_n = PH_DONE;
										end
									end
									default: phase_n = phase_q;
								endcase
							end
						end
					end
				end else begin
					// drop the byte and the whole line
					clear = 1'b1;
				end
			end
		end
		if (clear) begin
			stored_n = '0;
			prog_n   = '0;
			cc_n     = '0;
			phase_n  = PH_LEAD;
			acc_n    = '0;
			neg_n    = 1'b0;
			err_n    = 1'b0;
			ended_n  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (field_we) begin
			fields_q[cc_q] <= acc_q[7:0];
		end
		if (load_out) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= IDLE_TIMEOUT_RESET;
			idle_q      <= '0;
			stored_q    <= '0;
			prog_q      <= '0;
			cc_q        <= '0;
			phase_q     <= PH_LEAD;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			err_q       <= 1'b0;
			ended_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			idle_q   <= idle_n;
			stored_q <= stored_n;
			prog_q   <= prog_n;
			cc_q     <= cc_n;
			phase_q  <= phase_n;
			acc_q    <= acc_n;
			neg_q    <= neg_n;
			err_q    <= err_n;
			ended_q  <= ended_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== design/rgb_command_line_parser.sv =====
// RGB command line parser.
// in channel (in_valid/in_ready/in_data): one request per serial byte
// (command 0, data_byte holds the character) or per millisecond tick (command 1).
// out channel (out_valid/out_ready/out_data): one response per finished line
// that is not empty; status tells color, malformed RGB line or other line.
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes the 16-bit idle timeout in
// ticks; cfg_ready is always high. Write it only while no request is in flight.
// Throughput: one request per cycle while in_ready is high. A front end
// classifies each character into a two-entry queue; the back end updates the
// line state for one queued request per cycle and fills the output register.
// A line's CR or LF passes through the front-end queue, and its response is
// registered in the output register that drives out_valid.
// When the receiver stalls, the response is held in the output register; the
// back end keeps going until a second response is due, then the queue fills
// and in_ready drops.
// Reset clears the line, the idle count and the output register, and sets the
// timeout to 1000 ticks.
module rgb_command_line_parser #(
	parameter int LINE_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rcp_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rcp_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data
);
	import rcp_pkg::*;

	logic  item_valid;
	logic  item_pop;
	item_t item;

	assign cfg_ready = 1'b1;

	rcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item)
	);

	rcp_back #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== design/rcp_checker.sv =====
module rcp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input rcp_pkg::req_t in_data,
	input logic          out_valid,
	input logic          out_ready,
	input rcp_pkg::rsp_t out_data,
	input logic          cfg_valid,
	input logic          cfg_ready,
	input logic [15:0]   cfg_data
);
	import rcp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STATUS_COLOR ||
			out_data.status == STATUS_MALFORMED || out_data.status == STATUS_OTHER))
		else $error("bad status code");

	a_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STATUS_COLOR |->
			out_data.red == 8'd0 && out_data.green == 8'd0 &&
			out_data.blue == 8'd0 && out_data.brightness == 8'd0)
		else $error("color fields set on a failed line");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("response during reset");

endmodule

bind rgb_command_line_parser rcp_checker u_rcp_checker (.*);

// ===== tb/rgb_command_line_parser_checker.sv =====
module rgb_command_line_parser_checker
	import rcp_pkg::*;
#(
	parameter int LINE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  req_t        in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  rsp_t        out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          color_lines,
	output int          malformed_lines,
	output int          other_lines
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		MATCH_R, MATCH_G, MATCH_B, MATCH_COLON, MATCH_DONE, MATCH_FAIL
	} prefix_e;

	typedef enum logic [1:0] {
		FLD_LEAD, FLD_DIGITS, FLD_SKIP
	} field_e;

	localparam int CNT_W = $clog2(LINE_DEPTH);

	localparam logic [7:0]  CH_NUL    = 8'h00;
	localparam logic [7:0]  CH_TAB    = 8'h09;
	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [7:0]  CH_VT     = 8'h0B;
	localparam logic [7:0]  CH_FF     = 8'h0C;
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [7:0]  CH_SPACE  = 8'h20;
	localparam logic [7:0]  CH_PLUS   = "+";
	localparam logic [7:0]  CH_COMMA  = ",";
	localparam logic [7:0]  CH_MINUS  = "-";
	localparam logic [7:0]  CH_DIGIT0 = "0";
	localparam logic [7:0]  CH_DIGIT9 = "9";
	localparam logic [31:0] PREFIX_TEXT = "RGB:";

	logic [15:0]      timeout_ticks;
	logic [15:0]      idle_ticks;
	logic [CNT_W-1:0] stored;
	prefix_e          prefix;
	logic [1:0]       commas;
	field_e           phase;
	logic [8:0]       acc;
	logic             negative;
	logic             bad_range;
	logic             text_done;
	logic [7:0]       colors [4];
	rsp_t             expected_reports [$];

	function automatic void clear_line();
		stored    = '0;
		prefix    = MATCH_R;
		commas    = '0;
		phase     = FLD_LEAD;
		acc       = '0;
		negative  = 1'b0;
		bad_range = 1'b0;
		text_done = 1'b0;
		for (int i = 0; i < 4; i++)
			colors[i] = '0;
	endfunction

	// "-0" is a legal zero; any other negative value is out of range
	function automatic void close_field(input logic [1:0] slot);
		if (acc > 9'd255 || (negative && acc != 0))
			bad_range = 1'b1;
		colors[slot] = acc[7:0];
		phase    = FLD_LEAD;
		acc      = '0;
		negative = 1'b0;
	endfunction

	function automatic void scan_field_char(input logic [7:0] c);
		logic is_digit;
		int   sum;
		is_digit = (c >= CH_DIGIT0 && c <= CH_DIGIT9);
		// the fourth field runs to the end, later commas are plain text
		if (c == CH_COMMA && commas < LAST_COMMA) begin
			close_field(commas);
			commas++;
			return;
		end
		if (phase == FLD_LEAD) begin
			if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
				return;
			if (c == CH_PLUS || c == CH_MINUS) begin
				negative = (c == CH_MINUS);
				phase    = FLD_DIGITS;
				return;
			end
			phase = is_digit ? FLD_DIGITS : FLD_SKIP;
		end else if (phase == FLD_DIGITS && !is_digit) begin
			phase = FLD_SKIP;
		end
		if (phase == FLD_DIGITS && is_digit) begin
			sum = int'(acc) * 10 + int'(c) - int'(CH_DIGIT0);
			acc = (sum > 256) ? 9'd256 : sum[8:0];
		end
	endfunction

	function automatic void take_char(input logic [7:0] c);
		stored++;
		if (text_done)
			return;
		// a zero byte ends the text; the rest of the line is only counted
		if (c == CH_NUL) begin
			text_done = 1'b1;
			return;
		end
		if (prefix < MATCH_DONE) begin
			if (c == PREFIX_TEXT[31 - 8 * int'(prefix) -: 8])
				prefix = prefix_e'(prefix + 3'd1);
			else
				prefix = MATCH_FAIL;
		end else if (prefix == MATCH_DONE) begin
			scan_field_char(c);
		end
	endfunction

	function automatic void advance_line(input req_t r);
		rsp_t rep;
		if (r.command == CMD_TICK) begin
			if (idle_ticks != 16'hFFFF)
				idle_ticks++;
			if (stored != 0 && idle_ticks > timeout_ticks)
				clear_line();
			return;
		end
		idle_ticks = '0;
		if (r.data_byte != CH_LF && r.data_byte != CH_CR) begin
			// a byte that would fill the buffer is dropped with the line
			if (stored < LINE_DEPTH - 1)
				take_char(r.data_byte);
			else
				clear_line();
			return;
		end
		if (stored == 0)
			return;
		rep = '0;
		if (prefix != MATCH_DONE) begin
			rep.status = STATUS_OTHER;
		end else if (commas < 2'd2) begin
			rep.status = STATUS_MALFORMED;
		end else begin
			close_field(commas);
			if (commas == 2'd2)
				colors[3] = BRIGHTNESS_FULL;
			rep.status = bad_range ? STATUS_MALFORMED : STATUS_COLOR;
		end
		if (rep.status == STATUS_COLOR) begin
			rep.red        = colors[0];
			rep.green      = colors[1];
			rep.blue       = colors[2];
			rep.brightness = colors[3];
		end
		rep.line_length = 6'(stored);
		expected_reports.push_back(rep);
		clear_line();
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			clear_line();
			idle_ticks      = '0;
			timeout_ticks   = IDLE_TIMEOUT_RESET;
			expected_reports.delete();
			fail_count      = 0;
			color_lines     = 0;
			malformed_lines = 0;
			other_lines     = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				timeout_ticks = cfg_data;
			if (in_valid && in_ready)
				advance_line(in_data);
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("line report with none expected: status %0d, length %0d",
						out_data.status, out_data.line_length);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					case (want.status)
						STATUS_COLOR:     color_lines++;
						STATUS_MALFORMED: malformed_lines++;
						default:          other_lines++;
					endcase
					check_field("status", want.status, out_data.status);
					check_field("red", want.red, out_data.red);
					check_field("green", want.green, out_data.green);
					check_field("blue", want.blue, out_data.blue);
					check_field("brightness", want.brightness, out_data.brightness);
					check_field("line_length", want.line_length, out_data.line_length);
				end
			end
		end
		pending = expected_reports.size();
	end

endmodule

// ===== tb/rgb_command_line_parser_tb.sv =====
module rgb_command_line_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcp_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD    = 600;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	req_t        in_data;
	logic        out_valid;
	logic        out_ready;
	rsp_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	int fail_count;
	int pending;
	int color_lines;
	int malformed_lines;
	int other_lines;

	bit          no_gaps;
	bit          tick_mix;
	bit          long_hold_req;
	int          req_count;
	int          random_bytes;
	int          cycle_count;
	logic [15:0] last_timeout;
	logic [7:0]  line_buf [$];

	rgb_command_line_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	rgb_command_line_parser_checker line_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.color_lines     (color_lines),
		.malformed_lines (malformed_lines),
		.other_lines     (other_lines)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timed out after %0d cycles, %0d reports outstanding", cycle_count, pending);
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver: random hold-off per report, calm stretches, one long stall on request
	initial begin
		int hold;
		bit calm;
		calm      = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 11) == 0)
				calm = !calm;
			if (long_hold_req) begin
				hold          = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 10);
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_req(input logic cmd, input logic [7:0] b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req_t'{command: cmd, data_byte: b};
		do @(posedge clk); while (!in_ready);
		req_count++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		send_req(CMD_BYTE, b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// the data byte of a tick is ignored, so fill it with noise
	task automatic put_ticks(input int n);
		repeat (n) send_req(CMD_TICK, 8'($urandom()));
	endtask

	task automatic fast_ticks(input int n);
		no_gaps = 1'b1;
		put_ticks(n);
		no_gaps = 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		last_timeout = v;
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	function automatic void add_field();
		int blanks;
		int shape;
		int v;
		blanks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (blanks) begin
			case ($urandom_range(0, 3))
				0:       line_buf.push_back(CH_SPACE);
				1:       line_buf.push_back(CH_TAB);
				2:       line_buf.push_back(CH_VT);
				default: line_buf.push_back(CH_FF);
			endcase
		end
		case ($urandom_range(0, 23))
			0:       add_text("+");
			1:       add_text("-");
			default: ;
		endcase
		shape = $urandom_range(0, 15);
		if (shape != 0) begin
			if (shape == 1)
				add_text("00");
			v = (shape == 2) ? $urandom_range(256, 99999) : $urandom_range(0, 255);
			add_text($sformatf("%0d", v));
		end
		if ($urandom_range(0, 9) == 0)
			line_buf.push_back(8'($urandom_range(33, 126)));
	endfunction

	// Color command with random content, which may be malformed, now and then damaged
	function automatic void build_color_line();
		int n;
		int pos;
		line_buf.delete();
		add_text("RGB:");
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : $urandom_range(3, 4);
		for (int f = 0; f < n; f++) begin
			if (f > 0)
				add_text(",");
			add_field();
		end
		if ($urandom_range(0, 5) == 0) begin
			pos = $urandom_range(0, line_buf.size() - 1);
			case ($urandom_range(0, 3))
				0:       line_buf[pos] = 8'($urandom());
				1:       line_buf.insert(pos, CH_NUL);
				2:       line_buf.delete(pos);
				default: repeat ($urandom_range(40, 70)) line_buf.push_back(CH_SPACE);
			endcase
		end
	endfunction

	function automatic void build_noise_line();
		int len;
		line_buf.delete();
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 90) : $urandom_range(0, 20);
		repeat (len) line_buf.push_back(8'($urandom()));
	endfunction

	task automatic send_line();
		no_gaps = ($urandom_range(0, 3) == 0);
		foreach (line_buf[i]) begin
			if (tick_mix && $urandom_range(0, 15) == 0)
				put_ticks($urandom_range(1, 6));
			put_byte(line_buf[i]);
		end
		case ($urandom_range(0, 3))
			0: put_byte(CH_CR);
			1: put_byte(CH_LF);
			2: begin
				put_byte(CH_CR);
				put_byte(CH_LF);
			end
			default: begin
				put_byte(CH_LF);
				put_byte(CH_CR);
			end
		endcase
		random_bytes += line_buf.size();
		no_gaps = 1'b0;
	endtask

	task automatic random_lines(input int n);
		int target;
		target = random_bytes + n;
		while (random_bytes < target) begin
			if ($urandom_range(0, 4) == 0)
				build_noise_line();
			else
				build_color_line();
			send_line();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		no_gaps       = 1'b0;
		tick_mix      = 1'b0;
		long_hold_req = 1'b0;
		req_count     = 0;
		random_bytes  = 0;
		last_timeout  = IDLE_TIMEOUT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		put_text("RGB:0,0,0");
		put_byte(CH_CR);
		put_text("RGB:255,255,255,255");
		put_byte(CH_LF);
		put_text("RGB: +12,");
		put_byte(CH_TAB);
		put_text("-0,");
		put_byte(CH_VT);
		put_byte(CH_FF);
		put_text("7x9,  100");
		put_byte(CH_CR);
		put_byte(CH_LF);
		put_text("RGB:256,1,2");
		put_byte(CH_CR);
		put_text("RGB:1,-1,3");
		put_byte(CH_LF);
		put_text("RGB:1,2");
		put_byte(CH_CR);
		put_text("RGB:1,2,3,4,5");
		put_byte(CH_CR);
		put_text("RGB:,,");
		put_byte(CH_CR);
		put_text("RGB:99999,+-5,1");
		put_byte(CH_CR);
		put_text("rgb:1,2,3");
		put_byte(CH_CR);
		put_text("RGB");
		put_byte(CH_LF);
		put_text("RGB:1,2");
		put_byte(CH_NUL);
		put_text(",3");
		put_byte(CH_CR);
		put_byte(CH_NUL);
		put_text("RGB:1,2,3");
		put_byte(CH_CR);
		put_byte(8'hFF);
		put_byte(8'h80);
		put_byte(8'h7F);
		put_byte(CH_LF);
		// full buffer: the byte after 63 stored drops the line
		repeat (64) put_byte("A");
		put_text("RGB:1,2,3");
		put_byte(CH_CR);
		put_text("RGB:1,2,3,4");
		repeat (52) put_byte(CH_SPACE);
		put_byte(CH_CR);

		// idle stretches well under the reset timeout keep the line
		put_text("RGB:5,5,5");
		fast_ticks(40);
		put_byte(CH_CR);
		put_text("RGB:7");
		fast_ticks(40);
		put_text("9,9,9");
		put_byte(CH_CR);

		settle();
		write_timeout(16'd0);
		put_text("AB");
		put_ticks(1);
		put_byte(CH_CR);
		put_ticks(2);
		put_text("RGB:1,1,1");
		put_byte(CH_LF);

		settle();
		write_timeout(16'd2);
		put_text("RGB:3,");
		put_ticks(2);
		put_text("4,5");
		put_byte(CH_CR);
		put_text("RGB:");
		put_ticks(3);
		put_text("8,8,8");
		put_byte(CH_CR);

		// no timeout at all
		settle();
		write_timeout(16'hFFFF);
		put_text("RGB:1,2,3");
		fast_ticks(60);
		put_byte(CH_CR);

		settle();
		long_hold_req = 1'b1;
		random_lines(200);

		settle();
		write_timeout(16'd3);
		tick_mix = 1'b1;
		random_lines(150);

		settle();
		write_timeout(16'($urandom_range(4, 40)));
		random_lines(150);

		settle();
		$display("%0d requests sent (%0d random line bytes), %0d line reports checked",
			req_count, random_bytes, color_lines + malformed_lines + other_lines);
		$display("reports: %0d color, %0d malformed, %0d other; idle timeouts 1000 0 2 65535 3 %0d",
			color_lines, malformed_lines, other_lines, last_timeout);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
